/* design/uer_pkg.sv */
// Shared types and constants for the ultrasonic echo ranger.
`default_nettype none

package uer_pkg;

  // Trigger sequence lengths, in ticks
  localparam int PRE_TICKS   = 2;
  localparam int HIGH_TICKS  = 10;
  localparam int PAUSE_TICKS = 50;

  // Conversion constants
  localparam int US_PER_CM = 58;
  localparam int MM_PER_CM = 10;

  localparam int CM_W = 8;
  localparam int MM_W = 16;
  localparam logic [CM_W-1:0] CM_MAX = 8'd254;
  localparam logic [CM_W-1:0] CM_ERR = 8'd255;
  localparam logic [MM_W-1:0] MM_MAX = 16'hFFFE;
  localparam logic [MM_W-1:0] MM_ERR = 16'hFFFF;

  // Remainder width for the mod-58 running counters
  localparam int REM_W = 6;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int TIMEOUT_W  = 16;
  localparam int THRESH_W   = 8;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_THRESH = 1'b1;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST      = 16'd30000;
  localparam logic [THRESH_W-1:0]  THRESH_RST       = 8'd20;

  localparam int COUNT_WIDTH_DEF = 16;

  // One result item
  typedef struct packed {
    logic            trig;
    logic            busy;
    logic            done;
    logic            fault;
    logic [CM_W-1:0] cm;
    logic [MM_W-1:0] mm;
    logic            near;
  } res_t;

endpackage

`default_nettype wire

/* design/uer_in_stage.sv */
// Input register stage: captures start_req and echo of one accepted item.
`default_nettype none

module uer_in_stage
  import uer_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic in_start_req,
  input  wire logic in_echo,
  input  wire logic take,      // downstream can take the held item
  output logic      s1_valid,
  output logic      s1_start,
  output logic      s1_echo
);

  logic valid_r;
  logic start_r;
  logic echo_r;

  assign in_ready = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      start_r <= in_start_req;
      echo_r  <= in_echo;
    end
  end

  assign s1_valid = valid_r;
  assign s1_start = start_r;
  assign s1_echo  = echo_r;

endmodule

`default_nettype wire

/* design/uer_core.sv */
// Ranging sequencer: trigger timing, echo timing, distance counters, result.
`default_nettype none

module uer_core
  import uer_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  step,
  input  wire logic                  start,
  input  wire logic                  echo,
  output res_t                       res
);

  localparam int LIM_W = (COUNT_WIDTH > TIMEOUT_W) ? COUNT_WIDTH : TIMEOUT_W;
  localparam logic [LIM_W-1:0] COUNT_MAX = LIM_W'({COUNT_WIDTH{1'b1}});

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PRE,
    PH_HIGH,
    PH_PAUSE,
    PH_RISE,
    PH_MEAS
  } phase_t;

  logic [TIMEOUT_W-1:0]   timeout_r;
  logic [THRESH_W-1:0]    thresh_r;

  phase_t                 phase_r,     phase_nxt;
  logic [COUNT_WIDTH-1:0] phase_cnt_r, phase_cnt_nxt;
  logic [COUNT_WIDTH-1:0] width_cnt_r, width_cnt_nxt;
  logic [CM_W-1:0]        cm_q_r,      cm_q_nxt;
  logic [REM_W-1:0]       cm_rem_r,    cm_rem_nxt;
  logic [MM_W-1:0]        mm_q_r,      mm_q_nxt;
  logic [REM_W-1:0]       mm_rem_r,    mm_rem_nxt;
  logic [CM_W-1:0]        last_cm_r,   last_cm_nxt;
  logic [MM_W-1:0]        last_mm_r,   last_mm_nxt;
  logic                   last_near_r, last_near_nxt;
  logic                   last_fault_r, last_fault_nxt;

  logic [LIM_W-1:0]       timeout_ext;
  logic [LIM_W-1:0]       lim;
  logic                   lim_zero;
  phase_t                 ph_eff;
  logic [COUNT_WIDTH-1:0] pc_eff;
  logic [COUNT_WIDTH-1:0] pc_inc;
  logic                   trig;
  logic                   busy;
  logic                   fin;
  logic                   fin_err;
  logic [REM_W:0]         mm_rem_sum;

  // Effective timeout: register value limited to what the counters hold
  assign timeout_ext = LIM_W'(timeout_r);
  assign lim         = (timeout_ext < COUNT_MAX) ? timeout_ext : COUNT_MAX;
  assign lim_zero    = (lim == '0);

  assign mm_rem_sum  = {1'b0, mm_rem_r} + (REM_W + 1)'(MM_PER_CM);

  always_comb begin
    ph_eff = phase_r;
    pc_eff = phase_cnt_r;
    if (phase_r == PH_IDLE && start) begin
      ph_eff = PH_PRE;
      pc_eff = '0;
    end
    pc_inc = pc_eff + COUNT_WIDTH'(1);

    phase_nxt     = ph_eff;
    phase_cnt_nxt = pc_eff;
    width_cnt_nxt = width_cnt_r;
    cm_q_nxt      = cm_q_r;
    cm_rem_nxt    = cm_rem_r;
    mm_q_nxt      = mm_q_r;
    mm_rem_nxt    = mm_rem_r;
    trig          = 1'b0;
    busy          = 1'b0;
    fin           = 1'b0;
    fin_err       = 1'b0;

    case (ph_eff)
      PH_PRE: begin
        busy          = 1'b1;
        phase_cnt_nxt = pc_inc;
        if (pc_inc >= COUNT_WIDTH'(PRE_TICKS)) begin
          phase_nxt     = PH_HIGH;
          phase_cnt_nxt = '0;
        end
      end
      PH_HIGH: begin
        trig          = 1'b1;
        busy          = 1'b1;
        phase_cnt_nxt = pc_inc;
        if (pc_inc >= COUNT_WIDTH'(HIGH_TICKS)) begin
          phase_nxt     = PH_PAUSE;
          phase_cnt_nxt = '0;
        end
      end
      PH_PAUSE: begin
        busy          = 1'b1;
        phase_cnt_nxt = pc_inc;
        if (pc_inc >= COUNT_WIDTH'(PAUSE_TICKS)) begin
          phase_nxt     = PH_RISE;
          phase_cnt_nxt = '0;
        end
      end
      PH_RISE: begin
        if (echo) begin
          if (lim_zero) begin
            fin     = 1'b1;
            fin_err = 1'b1;
          end else begin
            // rise tick is the first high tick: width 1
            busy          = 1'b1;
            phase_nxt     = PH_MEAS;
            width_cnt_nxt = COUNT_WIDTH'(1);
            cm_q_nxt      = '0;
            cm_rem_nxt    = REM_W'(1);
            mm_q_nxt      = '0;
            mm_rem_nxt    = REM_W'(MM_PER_CM);
          end
        end else if (LIM_W'(pc_eff) >= lim) begin
          fin     = 1'b1;
          fin_err = 1'b1;
        end else begin
          busy          = 1'b1;
          phase_cnt_nxt = pc_inc;
        end
      end
      PH_MEAS: begin
        if (!echo) begin
          fin     = 1'b1;
          fin_err = (width_cnt_r == '0);
        end else if (LIM_W'(width_cnt_r) >= lim) begin
          fin     = 1'b1;
          fin_err = 1'b1;
        end else begin
          busy          = 1'b1;
          width_cnt_nxt = width_cnt_r + COUNT_WIDTH'(1);
          // running width/58, saturating
          if (cm_rem_r == REM_W'(US_PER_CM - 1)) begin
            cm_rem_nxt = '0;
            if (cm_q_r != CM_MAX) cm_q_nxt = cm_q_r + CM_W'(1);
          end else begin
            cm_rem_nxt = cm_rem_r + REM_W'(1);
          end
          // running width*10/58, saturating
          if (mm_rem_sum >= (REM_W + 1)'(US_PER_CM)) begin
            mm_rem_nxt = REM_W'(mm_rem_sum - (REM_W + 1)'(US_PER_CM));
            if (mm_q_r != MM_MAX) mm_q_nxt = mm_q_r + MM_W'(1);
          end else begin
            mm_rem_nxt = REM_W'(mm_rem_sum);
          end
        end
      end
      default: begin
        phase_nxt     = PH_IDLE;
        phase_cnt_nxt = '0;
      end
    endcase

    last_cm_nxt    = last_cm_r;
    last_mm_nxt    = last_mm_r;
    last_near_nxt  = last_near_r;
    last_fault_nxt = last_fault_r;
    if (fin) begin
      phase_nxt     = PH_IDLE;
      phase_cnt_nxt = '0;
      if (fin_err) begin
        last_cm_nxt    = CM_ERR;
        last_mm_nxt    = MM_ERR;
        last_near_nxt  = 1'b0;
        last_fault_nxt = 1'b1;
      end else begin
        last_cm_nxt    = cm_q_r;
        last_mm_nxt    = mm_q_r;
        last_near_nxt  = (cm_q_r <= thresh_r);
        last_fault_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r    <= TIMEOUT_RST;
      thresh_r     <= THRESH_RST;
      phase_r      <= PH_IDLE;
      phase_cnt_r  <= '0;
      width_cnt_r  <= '0;
      cm_q_r       <= '0;
      cm_rem_r     <= '0;
      mm_q_r       <= '0;
      mm_rem_r     <= '0;
      last_cm_r    <= CM_ERR;
      last_mm_r    <= MM_ERR;
      last_near_r  <= 1'b0;
      last_fault_r <= 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_TIMEOUT:      timeout_r <= cfg_wdata[TIMEOUT_W-1:0];
          REG_CLOSE_THRESH: thresh_r  <= cfg_wdata[THRESH_W-1:0];
          default: ;
        endcase
      end
      if (step) begin
        phase_r      <= phase_nxt;
        phase_cnt_r  <= phase_cnt_nxt;
        width_cnt_r  <= width_cnt_nxt;
        cm_q_r       <= cm_q_nxt;
        cm_rem_r     <= cm_rem_nxt;
        mm_q_r       <= mm_q_nxt;
        mm_rem_r     <= mm_rem_nxt;
        last_cm_r    <= last_cm_nxt;
        last_mm_r    <= last_mm_nxt;
        last_near_r  <= last_near_nxt;
        last_fault_r <= last_fault_nxt;
      end
    end
  end

  always_comb begin
    res.trig  = trig;
    res.busy  = busy && !fin;
    res.done  = fin;
    res.fault = last_fault_nxt;
    res.cm    = last_cm_nxt;
    res.mm    = last_mm_nxt;
    res.near  = last_near_nxt;
  end

endmodule

`default_nettype wire

/* design/uer_out_stage.sv */
// Result register stage: holds one result item until the consumer takes it.
`default_nettype none

module uer_out_stage
  import uer_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load_valid,
  input  res_t            res_in,
  output logic            can_take,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_trig,
  output logic            out_busy_res,
  output logic            out_done_res,
  output logic            out_fault,
  output logic [CM_W-1:0] out_range_cm,
  output logic [MM_W-1:0] out_range_mm,
  output logic            out_near
);

  logic valid_r;
  res_t res_r;

  assign can_take = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_take) begin
      valid_r <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && can_take) begin
      res_r <= res_in;
    end
  end

  assign out_valid    = valid_r;
  assign out_trig     = res_r.trig;
  assign out_busy_res = res_r.busy;
  assign out_done_res = res_r.done;
  assign out_fault    = res_r.fault;
  assign out_range_cm = res_r.cm;
  assign out_range_mm = res_r.mm;
  assign out_near     = res_r.near;

endmodule

`default_nettype wire

/* design/ultrasonic_echo_ranger.sv */
// Top level of the ultrasonic echo ranger.
// Each input item is one microsecond tick carrying a start request and the
// sampled echo level; every item yields exactly one result item with the
// trigger drive, busy/done flags and the last stored measurement (fault,
// cm, mm, near). A start while idle runs 2 low trigger ticks, 10 high
// ticks and a 50-tick pause, then times the echo: the wait for the rise
// and the high width each fault once they pass timeout_us (limited to the
// counter range). Distance comes from running divide-by-58 counters that
// advance with the width count, so cm (saturating at 254) and mm
// (width*10/58, saturating at 65534) are ready the tick the echo falls;
// errors report cm 255, mm 65535, near 0, fault 1.
// Rate: one item per clock while out_ready allows it. An item's result passes
// through the input register, then the sequencer update in uer_core feeding
// the result register, before it can be taken. A stalled result register
// holds the pipeline; the input register still takes one item meanwhile.
// Configuration writes (index 0 timeout_us, index 1 close_threshold_cm)
// take effect at once and are meant for idle periods only.
`default_nettype none

module ultrasonic_echo_ranger
  import uer_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF   // 12..24
)
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // input items
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_start_req,
  input  wire logic                  in_echo,
  // result items
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_trig,
  output logic                       out_busy_res,
  output logic                       out_done_res,
  output logic                       out_fault,
  output logic [CM_W-1:0]            out_range_cm,
  output logic [MM_W-1:0]            out_range_mm,
  output logic                       out_near
);

  logic s1_valid;
  logic s1_start;
  logic s1_echo;
  logic can_take;
  logic step;
  res_t res;

  // sequencer state advances exactly when an item moves into the result reg
  assign step = s1_valid && can_take;

  uer_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_start_req (in_start_req),
    .in_echo      (in_echo),
    .take         (can_take),
    .s1_valid     (s1_valid),
    .s1_start     (s1_start),
    .s1_echo      (s1_echo)
  );

  uer_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .start     (s1_start),
    .echo      (s1_echo),
    .res       (res)
  );

  uer_out_stage u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .load_valid   (s1_valid),
    .res_in       (res),
    .can_take     (can_take),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_trig     (out_trig),
    .out_busy_res (out_busy_res),
    .out_done_res (out_done_res),
    .out_fault    (out_fault),
    .out_range_cm (out_range_cm),
    .out_range_mm (out_range_mm),
    .out_near     (out_near)
  );

endmodule

`default_nettype wire
